[rtl/umrsa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// umrsa_pkg
// Shared types, request codes and controller commands for the USB MIDI
// receive path with sysex assembly.
// ----------------------------------------------------------------------------
package umrsa_pkg;

  // Default store depths
  localparam int MESSAGE_DEPTH_DEF = 64;
  localparam int SYSEX_DEPTH_DEF   = 2048;

  // Sysex length saturates here at most (12-bit length field)
  localparam int COUNT_MAX = 4095;

  // Request codes
  localparam logic [1:0] REQ_PUT  = 2'd0;
  localparam logic [1:0] REQ_READ = 2'd1;
  localparam logic [1:0] REQ_BYTE = 2'd2;
  localparam logic [1:0] REQ_TAKE = 2'd3;

  // Message kinds
  localparam logic [1:0] KIND_INVALID = 2'd0;
  localparam logic [1:0] KIND_CC      = 2'd1;
  localparam logic [1:0] KIND_PC      = 2'd2;
  localparam logic [1:0] KIND_SYSEX   = 2'd3;

  // MIDI byte values
  localparam logic [7:0] SX_START    = 8'hF0;
  localparam logic [7:0] SX_END      = 8'hF7;
  localparam logic [7:0] STAT_CC     = 8'hB0;
  localparam logic [7:0] STAT_PC     = 8'hC0;
  localparam logic [7:0] KIND_MASK   = 8'hF0;
  localparam int         CMD_BIT     = 7;

  // Packet byte select for sysex pushes
  localparam logic [1:0] BYTE_STATUS = 2'd0;
  localparam logic [1:0] BYTE_FIRST  = 2'd1;
  localparam logic [1:0] BYTE_LAST   = 2'd2;

  // Datapath operations
  localparam int         OP_W        = 3;
  localparam logic [2:0] OP_NONE     = 3'd0;
  localparam logic [2:0] OP_PUT      = 3'd1;
  localparam logic [2:0] OP_PUSH     = 3'd2;
  localparam logic [2:0] OP_CLR_DONE = 3'd3;
  localparam logic [2:0] OP_MSG_POP  = 3'd4;
  localparam logic [2:0] OP_MSG_LAT  = 3'd5;
  localparam logic [2:0] OP_SX_READ  = 3'd6;
  localparam logic [2:0] OP_TAKE     = 3'd7;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  header_byte;
    logic [7:0]  status_byte;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [10:0] sysex_offset;
  } umrsa_in_t;

  typedef struct packed {
    logic        ok;
    logic [1:0]  msg_kind;
    logic [3:0]  channel;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
    logic [7:0]  sysex_byte;
    logic [11:0] sysex_length;
  } umrsa_out_t;

  typedef struct packed {
    logic            load;
    logic [OP_W-1:0] op;
    logic [1:0]      byte_sel;
    logic            set_ok;
    logic            ok_val;
    logic            out_load;
  } umrsa_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       is_start;
    logic       sx_full;
    logic       act_next;
    logic       msg_full;
    logic       msg_empty;
    logic       sx_ready;
    logic       off_ok;
    logic       push_close;
  } umrsa_stat_t;

endpackage
`default_nettype wire

[rtl/umrsa_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// umrsa_datapath
// Message FIFO, sysex ring buffer, pointers, current message and the
// registered result, driven by controller commands.
// ----------------------------------------------------------------------------
module umrsa_datapath
  import umrsa_pkg::*;
#(
  parameter int MESSAGE_DEPTH = MESSAGE_DEPTH_DEF,
  parameter int SYSEX_DEPTH   = SYSEX_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire umrsa_in_t   in_data,
  input  wire umrsa_cmd_t  cmd,
  output umrsa_stat_t      stat,
  output umrsa_out_t       out_data
);

  localparam int MSG_AW = $clog2(MESSAGE_DEPTH);
  localparam int SX_AW  = $clog2(SYSEX_DEPTH);
  localparam int SW     = ((SX_AW > 12) ? SX_AW : 12) + 1;
  localparam logic [SW-1:0]     SX_D      = SW'(SYSEX_DEPTH);
  localparam logic [SX_AW-1:0]  SX_LAST   = SX_AW'(SYSEX_DEPTH - 1);
  localparam logic [MSG_AW-1:0] MSG_LAST  = MSG_AW'(MESSAGE_DEPTH - 1);
  localparam logic [11:0]       COUNT_CAP =
    (SYSEX_DEPTH < COUNT_MAX) ? 12'(SYSEX_DEPTH) : 12'(COUNT_MAX);

  logic [31:0]       msg_mem [MESSAGE_DEPTH];
  logic [7:0]        sx_mem  [SYSEX_DEPTH];

  umrsa_in_t         item_r;
  logic [MSG_AW-1:0] msg_wp_r, msg_rp_r;
  logic [31:0]       msg_rdata_r;
  logic [23:0]       cur_r;
  logic [SX_AW-1:0]  sx_wp_r, sx_rp_r;
  logic [7:0]        sx_rdata_r;
  logic [11:0]       sx_count_r;
  logic              active_r, done_r;
  logic              ok_r, sb_valid_r;
  logic [11:0]       slen_r;
  umrsa_out_t        out_r;

  logic [MSG_AW-1:0] msg_wp_inc, msg_rp_inc;
  logic [SX_AW-1:0]  sx_wp_inc;
  logic [SW-1:0]     sx_wp_ext, sx_rp_ext, sx_used;
  logic [SW-1:0]     rd_sum, rd_addr, take_sum, take_ptr;
  logic              sx_full, msg_full, msg_empty, sx_nz;
  logic              is_start, abort, act_next;
  logic [7:0]        push_byte;
  logic              msg_we, sx_we;
  logic [1:0]        kind;

  assign msg_wp_inc = (msg_wp_r == MSG_LAST) ? '0 : msg_wp_r + MSG_AW'(1);
  assign msg_rp_inc = (msg_rp_r == MSG_LAST) ? '0 : msg_rp_r + MSG_AW'(1);
  assign sx_wp_inc  = (sx_wp_r == SX_LAST) ? '0 : sx_wp_r + SX_AW'(1);
  assign msg_full   = (msg_wp_inc == msg_rp_r);
  assign msg_empty  = (msg_wp_r == msg_rp_r);
  assign sx_full    = (sx_wp_inc == sx_rp_r);
  assign sx_nz      = (sx_wp_r != sx_rp_r);

  assign sx_wp_ext = SW'(sx_wp_r);
  assign sx_rp_ext = SW'(sx_rp_r);
  assign sx_used   = (sx_wp_ext >= sx_rp_ext) ? sx_wp_ext - sx_rp_ext
                                              : sx_wp_ext + SX_D - sx_rp_ext;

  // Both sums stay below twice the depth, one subtract wraps them
  assign rd_sum   = sx_rp_ext + SW'(item_r.sysex_offset);
  assign rd_addr  = (rd_sum >= SX_D) ? rd_sum - SX_D : rd_sum;
  assign take_sum = sx_rp_ext + SW'(sx_count_r);
  assign take_ptr = (take_sum >= SX_D) ? take_sum - SX_D : take_sum;

  assign is_start = (item_r.status_byte == SX_START);
  assign abort    = active_r &&
                    (item_r.status_byte[CMD_BIT] || item_r.first_data[CMD_BIT] ||
                     item_r.second_data[CMD_BIT]) &&
                    (item_r.status_byte != SX_END) && (item_r.first_data != SX_END) &&
                    (item_r.second_data != SX_END);
  assign act_next = is_start ? 1'b1 : (abort ? 1'b0 : active_r);

  always_comb begin
    case (cmd.byte_sel)
      BYTE_STATUS: push_byte = item_r.status_byte;
      BYTE_FIRST:  push_byte = item_r.first_data;
      default:     push_byte = item_r.second_data;
    endcase
  end

  assign msg_we = (cmd.op == OP_PUT) && !act_next && !msg_full;
  assign sx_we  = (cmd.op == OP_PUSH) && !sx_full;

  always_comb begin
    if (sx_nz) begin
      kind = KIND_SYSEX;
    end else begin
      case (cur_r[23:16] & KIND_MASK)
        STAT_CC:  kind = KIND_CC;
        STAT_PC:  kind = KIND_PC;
        SX_START: kind = KIND_SYSEX;
        default:  kind = KIND_INVALID;
      endcase
    end
  end

  always_comb begin
    stat.req        = item_r.req_type;
    stat.is_start   = is_start;
    stat.sx_full    = sx_full;
    stat.act_next   = act_next;
    stat.msg_full   = msg_full;
    stat.msg_empty  = msg_empty;
    stat.sx_ready   = sx_nz && done_r;
    stat.off_ok     = (SW'(item_r.sysex_offset) < sx_used);
    stat.push_close = !sx_full && (push_byte == SX_END);
  end

  // Stores: one write and one registered read each
  always_ff @(posedge clk) begin
    if (msg_we) begin
      msg_mem[msg_wp_r] <= {item_r.header_byte, item_r.status_byte,
                            item_r.first_data, item_r.second_data};
    end
    if (cmd.op == OP_MSG_POP) begin
      msg_rdata_r <= msg_mem[msg_rp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (sx_we) begin
      sx_mem[sx_wp_r] <= push_byte;
    end
    if (cmd.op == OP_SX_READ) begin
      sx_rdata_r <= sx_mem[rd_addr[SX_AW-1:0]];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r     <= in_data;
      ok_r       <= 1'b0;
      sb_valid_r <= 1'b0;
      slen_r     <= '0;
    end else begin
      if (cmd.set_ok) begin
        ok_r <= cmd.ok_val;
      end else if (cmd.op == OP_TAKE) begin
        ok_r <= (sx_count_r != '0);
      end
      if (cmd.op == OP_SX_READ) begin
        sb_valid_r <= 1'b1;
      end
      if (cmd.op == OP_TAKE) begin
        slen_r <= sx_count_r;
      end
    end
    if (cmd.out_load) begin
      out_r.ok           <= ok_r;
      out_r.msg_kind     <= kind;
      out_r.channel      <= cur_r[19:16];
      out_r.data_one     <= cur_r[15:8];
      out_r.data_two     <= cur_r[7:0];
      out_r.sysex_byte   <= sb_valid_r ? sx_rdata_r : 8'd0;
      out_r.sysex_length <= slen_r;
    end
  end

  // Architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_wp_r   <= '0;
      msg_rp_r   <= '0;
      cur_r      <= '0;
      sx_wp_r    <= '0;
      sx_rp_r    <= '0;
      sx_count_r <= '0;
      active_r   <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      case (cmd.op)
        OP_PUT: begin
          active_r <= act_next;
          if (!is_start && abort) begin
            done_r <= 1'b0;
          end
          if (msg_we) begin
            msg_wp_r <= msg_wp_inc;
          end
        end
        OP_PUSH: begin
          if (sx_we) begin
            sx_wp_r <= sx_wp_inc;
            if (sx_count_r < COUNT_CAP) begin
              sx_count_r <= sx_count_r + 12'd1;
            end
            if (push_byte == SX_END) begin
              active_r <= 1'b0;
              done_r   <= 1'b1;
            end
          end
        end
        OP_CLR_DONE: done_r <= 1'b0;
        OP_MSG_POP:  msg_rp_r <= msg_rp_inc;
        OP_MSG_LAT:  cur_r <= msg_rdata_r[23:0];
        OP_TAKE: begin
          sx_rp_r    <= take_ptr[SX_AW-1:0];
          sx_count_r <= '0;
        end
        default: ;
      endcase
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

[rtl/umrsa_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// umrsa_ctrl
// Request sequencer: accepts one transaction, steps the datapath through
// it and hands the result to the output register.
// ----------------------------------------------------------------------------
module umrsa_ctrl
  import umrsa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  wire logic        out_stall,
  input  wire umrsa_stat_t stat,
  output umrsa_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_PUSH = 3'd2;
  localparam logic [2:0] S_MSGL = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.req)
          REQ_PUT: begin
            if (stat.is_start && stat.sx_full) begin
              cmd.set_ok = 1'b1;
              cmd.ok_val = 1'b0;
              state_nxt  = S_RESP;
            end else begin
              cmd.op = OP_PUT;
              if (stat.act_next) begin
                idx_nxt   = BYTE_STATUS;
                state_nxt = S_PUSH;
              end else begin
                cmd.set_ok = 1'b1;
                cmd.ok_val = !stat.msg_full;
                state_nxt  = S_RESP;
              end
            end
          end
          REQ_READ: begin
            cmd.set_ok = 1'b1;
            if (stat.sx_ready) begin
              cmd.op     = OP_CLR_DONE;
              cmd.ok_val = 1'b1;
              state_nxt  = S_RESP;
            end else if (!stat.msg_empty) begin
              cmd.op     = OP_MSG_POP;
              cmd.ok_val = 1'b1;
              state_nxt  = S_MSGL;
            end else begin
              cmd.ok_val = 1'b0;
              state_nxt  = S_RESP;
            end
          end
          REQ_BYTE: begin
            cmd.set_ok = 1'b1;
            cmd.ok_val = stat.off_ok;
            if (stat.off_ok) begin
              cmd.op = OP_SX_READ;
            end
            state_nxt = S_RESP;
          end
          default: begin
            cmd.op    = OP_TAKE;
            state_nxt = S_RESP;
          end
        endcase
      end
      S_PUSH: begin
        cmd.op       = OP_PUSH;
        cmd.byte_sel = idx_r;
        if (stat.push_close || idx_r == BYTE_LAST) begin
          cmd.set_ok = 1'b1;
          cmd.ok_val = 1'b1;
          state_nxt  = S_RESP;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
      S_MSGL: begin
        cmd.op    = OP_MSG_LAT;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= BYTE_STATUS;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

[rtl/usb_midi_rx_sysex_assembler.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// usb_midi_rx_sysex_assembler
// USB MIDI event packet receiver with sysex assembly into a ring buffer.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per transaction (put packet, read next, read sysex
//           byte, take sysex length). in_stall is high while a request is
//           being worked on; one request is handled at a time.
//   out_* : exactly one result transaction per request, held in an output
//           register, so the next request is taken while a result waits.
// Sequence: each request passes an execute state and a response state that
//   loads the result; a read-next that pops a message adds a latch state
//   (registered FIFO read), and a put that opens or continues a sysex adds a
//   push state, one byte into the ring buffer per cycle, stopping early at
//   the end byte. A new request is taken once the last result is loaded.
// Reset (rst_n low, synchronous): pointers, counts, sysex flags and current
//   message clear; stores keep their contents and need no clearing pass.
// Stall: while out_stall holds the result, the block finishes the next
//   request and then waits with in_stall high until the result is taken.
// ----------------------------------------------------------------------------
module usb_midi_rx_sysex_assembler
  import umrsa_pkg::*;
#(
  parameter int MESSAGE_DEPTH = MESSAGE_DEPTH_DEF,
  parameter int SYSEX_DEPTH   = SYSEX_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire umrsa_in_t  in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output umrsa_out_t      out_data
);

  umrsa_cmd_t  cmd;
  umrsa_stat_t stat;

  // Sequence each transaction through the datapath
  umrsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the stores, pointers and result register
  umrsa_datapath #(
    .MESSAGE_DEPTH (MESSAGE_DEPTH),
    .SYSEX_DEPTH   (SYSEX_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

[rtl/umrsa_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// umrsa_checker
// Port-level checks on the receiver, bound to the top level.
// ----------------------------------------------------------------------------
module umrsa_checker
  import umrsa_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire umrsa_out_t out_data
);

  // One request at a time: stall right after an accepted transaction
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted back to back");

  // A held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A nonzero length only comes from a successful take
  a_len_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.sysex_length != 12'd0 |-> out_data.ok &&
    out_data.sysex_byte == 8'd0)
    else $error("length without ok");

  // A nonzero sysex byte only comes from an in-range read
  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.sysex_byte != 8'd0 |-> out_data.ok)
    else $error("sysex byte without ok");

endmodule

bind usb_midi_rx_sysex_assembler umrsa_checker u_checker (.*);
`default_nettype wire
